@@ sv/evg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package evg_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 16;
   localparam int HOLD_W    = 16;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int EVENT_W   = 3;
   localparam int DIGIT_W   = 4;
   // root input and working widths of the square root stage
   localparam int ROOT_IN_W  = 32;
   localparam int ROOT_REM_W = 18;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE       = 3'd0,
      EV_OPEN       = 3'd1,
      EV_SILENCE    = 3'd2,
      EV_MAX        = 3'd3,
      EV_MAX_REOPEN = 3'd4
   } evt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEECH_LEVEL = 3'd0,
      CSR_ONSET_HOLD   = 3'd1,
      CSR_SILENCE_HOLD = 3'd2,
      CSR_MIN_CHUNK    = 3'd3,
      CSR_MAX_CHUNK    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_SOLVE,
      ST_DECIDE
   } top_state_type;

   typedef enum logic [1:0] {
      RS_IDLE,
      RS_DIV,
      RS_SQRT,
      RS_DONE
   } root_state_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] level;
   } root_stat_type;

endpackage

`default_nettype wire

@@ sv/evg_root.sv @@
`timescale 1ns / 1ps
`default_nettype none

module evg_root
   import evg_pkg::*;
#(
   parameter int SUM_W = 40,
   parameter int CNT_W = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output root_stat_type          stat
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam int ROOT_STEPS = ROOT_IN_W / 2;

   root_state_type state_ff, state_in;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SUM_W-1:0]      dq_ff, dq_in;
   logic [CNT_W-1:0]      div_ff;
   logic [CNT_W-1:0]      drem_ff, drem_in;
   logic [CNT_W:0]        drem_sh;
   logic                  dge;
   logic [ROOT_IN_W-1:0]  sq_ff, sq_in;
   logic [ROOT_REM_W-1:0] srem_ff, srem_in;
   logic [LEVEL_W-1:0]    root_ff, root_in;
   logic [ROOT_REM_W+1:0] srem_sh, trial;
   logic                  sge;

   // restoring division, one quotient bit a cycle
   assign drem_sh = {drem_ff, dq_ff[SUM_W-1]};
   assign dge     = drem_sh >= {1'b0, div_ff};
   assign dq_in   = {dq_ff[SUM_W-2:0], dge};
   assign drem_in = dge ? CNT_W'(drem_sh - {1'b0, div_ff}) : CNT_W'(drem_sh);

   // square root, two radicand bits a cycle
   assign srem_sh = {srem_ff, sq_ff[ROOT_IN_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sge     = srem_sh >= trial;
   assign srem_in = sge ? ROOT_REM_W'(srem_sh - trial) : ROOT_REM_W'(srem_sh);
   assign root_in = {root_ff[LEVEL_W-2:0], sge};
   assign sq_in   = {sq_ff[ROOT_IN_W-3:0], 2'b00};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RS_IDLE: if (start) state_in = RS_DIV;
         RS_DIV:  if (step_ff == '0) state_in = RS_SQRT;
         RS_SQRT: if (step_ff == '0) state_in = RS_DONE;
         RS_DONE: state_in = RS_IDLE;
         default: state_in = RS_IDLE;
      endcase
   end

   always_comb begin
      stat.done  = (state_ff == RS_DONE);
      stat.level = root_ff;
   end

   always_comb begin
      step_in = step_ff;
      unique case (state_ff)
         RS_IDLE: step_in = STEP_W'(SUM_W - 1);
         RS_DIV:  step_in = (step_ff == '0) ? STEP_W'(ROOT_STEPS - 1) : step_ff - 1'b1;
         RS_SQRT: step_in = step_ff - 1'b1;
         RS_DONE: step_in = step_ff;
         default: step_in = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      unique case (state_ff)
         RS_IDLE: begin
            if (start) begin
               dq_ff   <= dividend;
               div_ff  <= divisor;
               drem_ff <= '0;
            end
         end
         RS_DIV: begin
            dq_ff   <= dq_in;
            drem_ff <= drem_in;
            if (step_ff == '0) begin
               sq_ff   <= ROOT_IN_W'(dq_in);
               srem_ff <= '0;
               root_ff <= '0;
            end
         end
         RS_SQRT: begin
            sq_ff   <= sq_in;
            srem_ff <= srem_in;
            root_ff <= root_in;
         end
         RS_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/energy_voice_activity_gate.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  ports                                     beat
// req      in         sample, block_end, now_ms                 one audio sample
// rsp      out        rms_level, speech, capturing, chunk_event one finished block
// csr      in         we, index, wdata                          one register write
//
// a sample's magnitude is squared one 4-bit digit per cycle into the running
// sum, and the next sample is taken in the cycle of its last digit.
// a block end then runs a bit-serial divide over SUM_W = 31 + clog2(MAX_BLOCK_SAMPLES)
// bits, a 2-bit-per-cycle root, a hand-over, a decision and an idle state.
// reset is synchronous; it restores the register defaults and closes any chunk.
// a waiting result blocks only the next block end, samples keep flowing.

module energy_voice_activity_gate
   import evg_pkg::*;
#(
   parameter int MAX_BLOCK_SAMPLES = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [SAMPLE_W-1:0]  req_sample,
   input  wire logic                 req_block_end,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [LEVEL_W-1:0]   rsp_rms_level,
   output      logic                 rsp_speech,
   output      logic                 rsp_capturing,
   output      logic [EVENT_W-1:0]   rsp_chunk_event,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int SUM_W = 31 + $clog2(MAX_BLOCK_SAMPLES);
   localparam int DIGITS = SAMPLE_W / DIGIT_W;
   localparam int DIG_IDX_W = $clog2(DIGITS);
   localparam int PROD_W = SAMPLE_W + DIGIT_W;

   top_state_type state_ff, state_in;

   // registers
   logic [LEVEL_W-1:0] speech_level_ff;
   logic [HOLD_W-1:0]  onset_hold_ff, silence_hold_ff;
   logic [TIME_W-1:0]  min_chunk_ff, max_chunk_ff;

   // sample front end
   logic                 accept;
   logic [SAMPLE_W-1:0]  mag_ff, mag_in;
   logic [SAMPLE_W-1:0]  dig_ff;
   logic [DIG_IDX_W-1:0] k_ff;
   logic                 last_ff, take_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [SUM_W-1:0]     sum_ff, sum_add, sum_in;
   logic [PROD_W-1:0]    prod;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 mac_last, start, commit;

   root_stat_type      root_stat;
   logic [LEVEL_W-1:0] rms_ff;

   // detector state
   logic              pending_ff, pending_in;
   logic              open_ff, open_in;
   logic              sil_run_ff, sil_run_in;
   logic [TIME_W-1:0] onset_time_ff, onset_time_in;
   logic [TIME_W-1:0] sil_time_ff, sil_time_in;
   logic [TIME_W-1:0] chunk_time_ff, chunk_time_in;
   logic [TIME_W-1:0] onset_age, sil_age, chunk_age;
   logic              speech;
   logic              closed;
   evt_type           event_in;

   logic                rsp_valid_ff;
   logic [LEVEL_W-1:0]  rsp_rms_ff;
   logic                rsp_speech_ff, rsp_capturing_ff;
   evt_type             rsp_event_ff;

   // ---------------- control ----------------

   assign mac_last = (state_ff == ST_MAC) && (k_ff == DIG_IDX_W'(DIGITS - 1));
   assign accept   = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MAC;
         ST_MAC: begin
            if (mac_last) begin
               if (last_ff)     state_in = ST_SOLVE;
               else if (accept) state_in = ST_MAC;
               else             state_in = ST_IDLE;
            end
         end
         ST_SOLVE:  if (root_stat.done) state_in = ST_DECIDE;
         ST_DECIDE: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE) || (mac_last && !last_ff);
      start     = mac_last && last_ff;
      commit    = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- configuration ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         speech_level_ff <= LEVEL_W'(500);
         onset_hold_ff   <= HOLD_W'(100);
         silence_hold_ff <= HOLD_W'(2000);
         min_chunk_ff    <= TIME_W'(5000);
         max_chunk_ff    <= TIME_W'(300000);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPEECH_LEVEL: speech_level_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_ONSET_HOLD:   onset_hold_ff   <= csr_wdata[HOLD_W-1:0];
            CSR_SILENCE_HOLD: silence_hold_ff <= csr_wdata[HOLD_W-1:0];
            CSR_MIN_CHUNK:    min_chunk_ff    <= csr_wdata[TIME_W-1:0];
            CSR_MAX_CHUNK:    max_chunk_ff    <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- square accumulate ----------------

   // magnitude wraps -32768 to 0x8000, which is the right unsigned value
   assign mag_in  = req_sample[SAMPLE_W-1] ? (~req_sample + 1'b1) : req_sample;
   assign prod    = PROD_W'(mag_ff) * PROD_W'(dig_ff[DIGIT_W-1:0]);
   assign sum_add = sum_ff + ((take_ff && state_ff == ST_MAC) ?
                    (SUM_W'(prod) << {k_ff, 2'b00}) : SUM_W'(0));
   assign sum_in  = start ? '0 : sum_add;

   always_comb begin
      count_in = count_ff;
      if (start) begin
         count_in = '0;
      end else if (accept && count_ff < CNT_W'(MAX_BLOCK_SAMPLES)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         if (accept) begin
            k_ff <= '0;
         end else if (state_ff == ST_MAC) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff  <= mag_in;
         dig_ff  <= mag_in;
         last_ff <= req_block_end;
         now_ff  <= req_now_ms;
         take_ff <= count_ff < CNT_W'(MAX_BLOCK_SAMPLES);
      end else if (state_ff == ST_MAC) begin
         dig_ff <= dig_ff >> DIGIT_W;
      end
   end

   // ---------------- mean and root ----------------

   evg_root #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (sum_add),
      .divisor  (count_ff),
      .stat     (root_stat)
   );

   always_ff @(posedge clock) begin
      if (root_stat.done) begin
         rms_ff <= root_stat.level;
      end
   end

   // ---------------- chunk decision ----------------

   assign speech    = rms_ff >= speech_level_ff;
   assign onset_age = now_ff - onset_time_ff;
   assign sil_age   = now_ff - sil_time_ff;
   assign chunk_age = now_ff - chunk_time_ff;

   always_comb begin
      pending_in    = pending_ff;
      open_in       = open_ff;
      sil_run_in    = sil_run_ff;
      onset_time_in = onset_time_ff;
      sil_time_in   = sil_time_ff;
      chunk_time_in = chunk_time_ff;
      event_in      = EV_NONE;
      closed        = 1'b0;
      if (!open_ff) begin
         if (speech) begin
            if (!pending_ff) begin
               pending_in    = 1'b1;
               onset_time_in = now_ff;
            end else if (onset_age >= TIME_W'(onset_hold_ff)) begin
               open_in       = 1'b1;
               chunk_time_in = now_ff;
               sil_run_in    = 1'b0;
               event_in      = EV_OPEN;
            end
         end else begin
            pending_in = 1'b0;
         end
      end else begin
         priority if (speech) begin
            sil_run_in = 1'b0;
         end else if (!sil_run_ff) begin
            sil_run_in  = 1'b1;
            sil_time_in = now_ff;
         end else if (sil_age >= TIME_W'(silence_hold_ff)) begin
            open_in  = 1'b0;
            event_in = EV_SILENCE;
            closed   = 1'b1;
         end else begin
         end
         if (!closed) begin
            if (chunk_age >= max_chunk_ff) begin
               if (speech) begin
                  chunk_time_in = now_ff;
                  sil_run_in    = 1'b0;
                  event_in      = EV_MAX_REOPEN;
               end else begin
                  open_in  = 1'b0;
                  event_in = EV_MAX;
               end
            end else if (chunk_age < min_chunk_ff) begin
               sil_run_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         open_ff    <= 1'b0;
         sil_run_ff <= 1'b0;
      end else if (commit) begin
         pending_ff <= pending_in;
         open_ff    <= open_in;
         sil_run_ff <= sil_run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         onset_time_ff <= onset_time_in;
         sil_time_ff   <= sil_time_in;
         chunk_time_ff <= chunk_time_in;
      end
   end

   // ---------------- result register ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_rms_ff       <= rms_ff;
         rsp_speech_ff    <= speech;
         rsp_capturing_ff <= open_in;
         rsp_event_ff     <= event_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_level   = rsp_rms_ff;
   assign rsp_speech      = rsp_speech_ff;
   assign rsp_capturing   = rsp_capturing_ff;
   assign rsp_chunk_event = rsp_event_ff;

   // ---------------- checks ----------------

   a_root_done_in_solve: assert property (@(posedge clock) disable iff (reset)
      root_stat.done |-> state_ff == ST_SOLVE)
      else $error("root result outside solve");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCK_SAMPLES))
      else $error("sample count past block limit");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      start |=> sum_ff == '0 && count_ff == '0)
      else $error("accumulator not cleared at block end");

   a_event_vs_capture: assert property (@(posedge clock) disable iff (reset)
      commit |=> ((rsp_chunk_event == EV_SILENCE || rsp_chunk_event == EV_MAX) ==
                  (!rsp_capturing && $past(open_ff))))
      else $error("close event does not match capture flag");

endmodule

`default_nettype wire
